FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the real-time clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define RTCST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rtcst: invariant violated");
// An implication checked in the same cycle.
`define RTCST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtcst: implication violated");
// An implication whose consequent is checked in the cycle after the antecedent.
`define RTCST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtcst: sequence violated");
`else
`define RTCST_ASSERT(lbl, clk, rst, prop)
`define RTCST_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RTCST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/rtcst_pkg.sv
// Types and constants of the real-time clock with countdown timers.
package rtcst_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int TIMER_W        = 32;
   localparam int TIMER_INDEX_W  = 4;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;

   localparam logic [4:0]  HOUR_RESET   = 5'd12;
   localparam logic [7:0]  INACT_RESET  = 8'd30;
   localparam logic [7:0]  PWRON_RESET  = 8'd3;
   localparam logic [15:0] DIM_RESET    = 16'd10;
   localparam logic [6:0]  SIXTY        = 7'd60;
   localparam logic [5:0]  TWENTY_FOUR  = 6'd24;

   localparam logic [CSR_INDEX_W-1:0] CSR_INACT_RELOAD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWRON_RELOAD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_LEVEL    = 2'd2;

   typedef enum logic [2:0] {
      FN_TICK       = 3'd0,
      FN_SET_TIME   = 3'd1,
      FN_READ_TIME  = 3'd2,
      FN_SET_TIMER  = 3'd3,
      FN_READ_TIMER = 3'd4,
      FN_ACTIVITY   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

endpackage

FILE: src/rtcst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rtcst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rtc_tick_with_soft_timers.sv
// Top level of the real-time clock with countdown timers, power-on and dimming logic.
//
// Usage: items arrive on the req_ channel (valid/ready) and each gives exactly one
// result on the rsp_ channel (valid/ready). Configuration registers are written
// through csr_we/csr_index/csr_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce. Reload values take effect at
// the next reload of the counter they feed, the dim level at the next dimming.
// Sequencing: a tick walks every countdown timer through the timer RAM, one entry
// per cycle with read and write-back overlapped, before its done state. Any other
// item goes straight to the done state, a timer read using the RAM's read port as
// it is accepted. The done state loads the result once the output register is free.
// Throughput: one item at a time; req_ready is high only while no item is at work.
// A finished result waits in the output register, and the next item is accepted
// meanwhile; it completes into that register once the receiver has taken the first.
// If the receiver stalls, the block holds its second result until rsp_ready.
// Reset: the clock shows 12:00:00, the counters load their reset reloads and the
// timers read as zero, since a valid bit per entry is cleared at once (no sweep).
module rtc_tick_with_soft_timers
   import rtcst_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_func,
   input  logic                     req_power_is_on,
   input  logic                     req_button_released,
   input  logic [15:0]              req_backlight_now,
   input  logic [4:0]               req_new_hour,
   input  logic [5:0]               req_new_minute,
   input  logic [5:0]               req_new_second,
   input  logic [TIMER_INDEX_W-1:0] req_timer_index,
   input  logic [TIMER_W-1:0]       req_timer_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [4:0]               rsp_hour,
   output logic [5:0]               rsp_minute,
   output logic [5:0]               rsp_second,
   output logic [TIMER_W-1:0]       rsp_timer_value,
   output logic                     rsp_power_on_request,
   output logic                     rsp_backlight_write,
   output logic [15:0]              rsp_backlight_value,
   output logic                     rsp_dimmed,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

`include "assert_macros.svh"

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TIMERS);

   // Configuration registers
   logic [7:0]  inact_reload_ff;
   logic [7:0]  pwron_reload_ff;
   logic [15:0] dim_level_ff;

   // Scalar state
   logic [4:0]  hours_ff, hours_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [7:0]  idle_count_ff, idle_count_in;
   logic [15:0] saved_bl_ff, saved_bl_in;
   logic        dim_flag_ff, dim_flag_in;
   logic [7:0]  hold_count_ff, hold_count_in;
   logic        wake_flag_ff, wake_flag_in;

   // Item in flight
   func_type    func_ff;
   logic        in_range_ff;
   logic        bl_wr_ff, bl_wr_in;
   logic [15:0] bl_val_ff, bl_val_in;

   // Sequencer and timer RAM
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   wr_addr_ff;
   logic [NUM_TIMERS-1:0] vld_ff;
   logic               rd_valid_ff;

   logic               accept;
   logic               in_range;
   func_type           req_fn;
   logic               rd_en, wr_en, rsp_load;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [TIMER_W-1:0] wr_data, rd_data, rd_word;

   // Output register
   logic               rsp_valid_ff;
   logic [4:0]         rsp_hour_ff;
   logic [5:0]         rsp_minute_ff, rsp_second_ff;
   logic [TIMER_W-1:0] rsp_timer_value_ff;
   logic               rsp_wake_ff, rsp_bl_wr_ff, rsp_dimmed_ff;
   logic [15:0]        rsp_bl_val_ff;

   assign req_fn   = func_type'(req_func);
   assign accept   = req_valid & req_ready;
   assign in_range = {1'b0, req_timer_index} < (TIMER_INDEX_W + 1)'(NUM_TIMERS);

   // An entry never written since reset reads as zero.
   assign rd_word = rd_valid_ff ? rd_data : '0;

   // Scalar update for the accepted item, applied at acceptance.
   always_comb begin
      logic [6:0] sec_inc;
      logic [6:0] min_inc;
      logic [5:0] hour_inc;
      hours_in      = hours_ff;
      minutes_in    = minutes_ff;
      seconds_in    = seconds_ff;
      idle_count_in = idle_count_ff;
      saved_bl_in   = saved_bl_ff;
      dim_flag_in   = dim_flag_ff;
      hold_count_in = hold_count_ff;
      wake_flag_in  = wake_flag_ff;
      bl_wr_in      = 1'b0;
      bl_val_in     = '0;
      sec_inc  = {1'b0, seconds_ff} + 7'd1;
      min_inc  = {1'b0, minutes_ff} + 7'd1;
      hour_inc = {1'b0, hours_ff} + 6'd1;
      unique case (req_fn)
         FN_TICK: begin
            if (sec_inc >= SIXTY) begin
               seconds_in = '0;
               if (min_inc >= SIXTY) begin
                  minutes_in = '0;
                  hours_in   = (hour_inc >= TWENTY_FOUR) ? 5'd0 : hour_inc[4:0];
               end else begin
                  minutes_in = min_inc[5:0];
               end
            end else begin
               seconds_in = sec_inc[5:0];
            end
            if (!req_power_is_on) begin
               if (req_button_released) begin
                  hold_count_in = pwron_reload_ff;
                  wake_flag_in  = 1'b0;
               end else begin
                  hold_count_in = hold_count_ff - 8'd1;
                  if (hold_count_in == 8'd0) begin
                     wake_flag_in = 1'b1;
                  end
               end
            end else begin
               idle_count_in = idle_count_ff - 8'd1;
               if (idle_count_in == 8'd0 && !dim_flag_ff) begin
                  saved_bl_in = req_backlight_now;
                  bl_wr_in    = 1'b1;
                  bl_val_in   = dim_level_ff;
                  dim_flag_in = 1'b1;
               end
            end
         end
         FN_SET_TIME: begin
            hours_in   = req_new_hour;
            minutes_in = req_new_minute;
            seconds_in = req_new_second;
         end
         FN_ACTIVITY: begin
            idle_count_in = inact_reload_ff;
            if (dim_flag_ff) begin
               bl_wr_in  = 1'b1;
               bl_val_in = saved_bl_ff;
            end
            dim_flag_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_fn == FN_TICK) ? ST_SWEEP : ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == CNT_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: the sweep reads entry k while it writes back entry k-1.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cnt_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = wr_addr_ff;
      wr_data   = (rd_word != '0) ? rd_word - TIMER_W'(1) : '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && in_range && req_fn == FN_READ_TIMER) begin
               rd_en   = 1'b1;
               rd_addr = req_timer_index[IDX_W-1:0];
            end
            if (req_valid && in_range && req_fn == FN_SET_TIMER) begin
               wr_en   = 1'b1;
               wr_addr = req_timer_index[IDX_W-1:0];
               wr_data = req_timer_load;
            end
         end
         ST_SWEEP: begin
            rd_en = (cnt_ff != CNT_END);
            wr_en = pend_ff;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   rtcst_ram #(
      .WIDTH (TIMER_W),
      .DEPTH (NUM_TIMERS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inact_reload_ff <= INACT_RESET;
         pwron_reload_ff <= PWRON_RESET;
         dim_level_ff    <= DIM_RESET;
         hours_ff        <= HOUR_RESET;
         minutes_ff      <= '0;
         seconds_ff      <= '0;
         idle_count_ff   <= INACT_RESET;
         saved_bl_ff     <= '0;
         dim_flag_ff     <= 1'b0;
         hold_count_ff   <= PWRON_RESET;
         wake_flag_ff    <= 1'b0;
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         pend_ff         <= 1'b0;
         vld_ff          <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INACT_RELOAD: inact_reload_ff <= csr_wdata[7:0];
               CSR_PWRON_RELOAD: pwron_reload_ff <= csr_wdata[7:0];
               CSR_DIM_LEVEL:    dim_level_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            hours_ff      <= hours_in;
            minutes_ff    <= minutes_in;
            seconds_ff    <= seconds_in;
            idle_count_ff <= idle_count_in;
            saved_bl_ff   <= saved_bl_in;
            dim_flag_ff   <= dim_flag_in;
            hold_count_ff <= hold_count_in;
            wake_flag_ff  <= wake_flag_in;
         end
         state_ff <= state_in;
         if (accept) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_SWEEP && cnt_ff != CNT_END) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         pend_ff <= (state_ff == ST_SWEEP) && (cnt_ff != CNT_END);
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= vld_ff[rd_addr];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item fields, the sweep's write address and the result register need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_fn;
         in_range_ff <= in_range;
         bl_wr_ff    <= bl_wr_in;
         bl_val_ff   <= bl_val_in;
      end
      wr_addr_ff <= cnt_ff[IDX_W-1:0];
      if (rsp_load) begin
         rsp_hour_ff        <= hours_ff;
         rsp_minute_ff      <= minutes_ff;
         rsp_second_ff      <= seconds_ff;
         rsp_timer_value_ff <= (func_ff == FN_READ_TIMER && in_range_ff) ? rd_word : '0;
         rsp_wake_ff        <= wake_flag_ff;
         rsp_bl_wr_ff       <= bl_wr_ff;
         rsp_bl_val_ff      <= bl_val_ff;
         rsp_dimmed_ff      <= dim_flag_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hour             = rsp_hour_ff;
   assign rsp_minute           = rsp_minute_ff;
   assign rsp_second           = rsp_second_ff;
   assign rsp_timer_value      = rsp_timer_value_ff;
   assign rsp_power_on_request = rsp_wake_ff;
   assign rsp_backlight_write  = rsp_bl_wr_ff;
   assign rsp_backlight_value  = rsp_bl_val_ff;
   assign rsp_dimmed           = rsp_dimmed_ff;

   // The sweep must never read and write the same timer in the same cycle.
   `RTCST_ASSERT_IMP(a_no_same_entry, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   // The sweep counter never runs past NUM_TIMERS, one beyond the last timer.
   `RTCST_ASSERT_IMP(a_cnt_bound, clock, reset, state_ff == ST_SWEEP, cnt_ff <= CNT_END)
   // An accepted tick always starts a sweep.
   `RTCST_ASSERT_NEXT(a_tick_sweeps, clock, reset, accept && req_fn == FN_TICK, state_ff == ST_SWEEP)
   // A result is loaded only once the previous one has been taken.
   `RTCST_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)

endmodule
